// ----- rtl/core/hrs_pkg.sv -----
// Shared types and constants of the HVAC relay supervisor: item kinds, register
// indexes, fixed field widths and the microcode program with its control words.
// Depends on nothing; used by hrs_rem_unit and hvac_relay_supervisor.
`default_nettype none

package hrs_pkg;

   localparam int TimeW  = 32;
   localparam int CircW  = 11;
   localparam int SetpW  = 16;
   localparam int HvacW  = 3;
   localparam int FanW   = 2;
   localparam int CmdSeqW = 16;
   localparam int PcW    = 4;
   localparam int ReqW   = 80;
   localparam int RspW   = 64;

   localparam logic [TimeW-1:0] MinuteMs       = 32'd60000;
   localparam logic [TimeW-1:0] MinuteSec      = 32'd60;
   localparam logic [TimeW-1:0] FsTimeoutReset = 32'd300000;

   localparam logic [FanW-1:0] FAN_ALWAYS_ON = 2'd1;
   localparam logic [FanW-1:0] FAN_CIRCULATE = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_HEARTBEAT = 2'd1,
      KIND_COMMAND   = 2'd2,
      KIND_LOCKOUT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FS_TIMEOUT   = 2'd0,
      CSR_CIRC_PERIOD  = 2'd1,
      CSR_CIRC_DUR     = 2'd2,
      CSR_SPARE_ACTIVE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FAILSAFE,
      OP_DRIVE,
      OP_MARK,
      OP_MOD_START,
      OP_LOAD_REM,
      OP_MINUTE,
      OP_INTERLOCK,
      OP_HEARTBEAT,
      OP_COMMAND,
      OP_LOCKOUT,
      OP_RESPOND
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_KIND,
      COND_MARK_ZERO,
      COND_REM_BUSY,
      COND_NO_MINUTE,
      COND_END
   } cond_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [PcW-1:0]     target;
   } uword_type;

   localparam logic [PcW-1:0] PC_DISPATCH  = 4'd0;
   localparam logic [PcW-1:0] PC_FAILSAFE  = 4'd1;
   localparam logic [PcW-1:0] PC_DRIVE     = 4'd2;
   localparam logic [PcW-1:0] PC_MARK      = 4'd3;
   localparam logic [PcW-1:0] PC_MOD_START = 4'd4;
   localparam logic [PcW-1:0] PC_MOD_WAIT  = 4'd5;
   localparam logic [PcW-1:0] PC_LOAD_REM  = 4'd6;
   localparam logic [PcW-1:0] PC_MIN_TEST  = 4'd7;
   localparam logic [PcW-1:0] PC_MINUTE    = 4'd8;
   localparam logic [PcW-1:0] PC_INTERLOCK = 4'd9;
   localparam logic [PcW-1:0] PC_RESPOND   = 4'd10;
   localparam logic [PcW-1:0] PC_HEARTBEAT = 4'd11;
   localparam logic [PcW-1:0] PC_COMMAND   = 4'd12;
   localparam logic [PcW-1:0] PC_LOCKOUT   = 4'd13;

   // The control store. Each word names the datapath operation of its step and
   // how the step counter moves afterwards.
   function automatic uword_type ucode(input logic [PcW-1:0] pc);
      uword_type w;
      case (pc)
         PC_DISPATCH:  w = '{OP_NOP,        COND_KIND,      PC_DISPATCH};
         PC_FAILSAFE:  w = '{OP_FAILSAFE,   COND_NEXT,      PC_DISPATCH};
         PC_DRIVE:     w = '{OP_DRIVE,      COND_NEXT,      PC_DISPATCH};
         PC_MARK:      w = '{OP_MARK,       COND_MARK_ZERO, PC_INTERLOCK};
         PC_MOD_START: w = '{OP_MOD_START,  COND_NEXT,      PC_DISPATCH};
         PC_MOD_WAIT:  w = '{OP_NOP,        COND_REM_BUSY,  PC_MOD_WAIT};
         PC_LOAD_REM:  w = '{OP_LOAD_REM,   COND_NEXT,      PC_DISPATCH};
         PC_MIN_TEST:  w = '{OP_NOP,        COND_NO_MINUTE, PC_INTERLOCK};
         PC_MINUTE:    w = '{OP_MINUTE,     COND_ALWAYS,    PC_MIN_TEST};
         PC_INTERLOCK: w = '{OP_INTERLOCK,  COND_NEXT,      PC_DISPATCH};
         PC_RESPOND:   w = '{OP_RESPOND,    COND_END,       PC_RESPOND};
         PC_HEARTBEAT: w = '{OP_HEARTBEAT,  COND_ALWAYS,    PC_RESPOND};
         PC_COMMAND:   w = '{OP_COMMAND,    COND_ALWAYS,    PC_RESPOND};
         PC_LOCKOUT:   w = '{OP_LOCKOUT,    COND_ALWAYS,    PC_RESPOND};
         default:      w = '{OP_NOP,        COND_ALWAYS,    PC_RESPOND};
      endcase
      return w;
   endfunction

   function automatic logic [PcW-1:0] entry_addr(input kind_type k);
      logic [PcW-1:0] a;
      case (k)
         KIND_TICK:      a = PC_FAILSAFE;
         KIND_HEARTBEAT: a = PC_HEARTBEAT;
         KIND_COMMAND:   a = PC_COMMAND;
         KIND_LOCKOUT:   a = PC_LOCKOUT;
         default:        a = PC_RESPOND;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hrs_rem_unit.sv -----
// Iterative remainder unit: 32-bit dividend modulo an 11-bit divisor, one
// quotient bit per cycle. Depends on hrs_pkg for the field widths.
`default_nettype none

module hrs_rem_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [hrs_pkg::TimeW-1:0] dividend,
   input  wire logic [hrs_pkg::CircW-1:0] divisor,
   output logic                           busy,
   output logic [hrs_pkg::CircW-1:0]      rem
);

   localparam int CntW = $clog2(hrs_pkg::TimeW + 1);

   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [hrs_pkg::TimeW-1:0]   shift_ff, shift_in;
   logic [hrs_pkg::CircW-1:0]   part_ff, part_in;
   logic [hrs_pkg::CircW:0]     trial;
   logic [hrs_pkg::CircW:0]     diff;

   assign trial = {part_ff, shift_ff[hrs_pkg::TimeW-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      part_in  = part_ff;
      if (start) begin
         cnt_in   = CntW'(hrs_pkg::TimeW);
         shift_in = dividend;
         part_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in   = cnt_ff - CntW'(1);
         shift_in = {shift_ff[hrs_pkg::TimeW-2:0], 1'b0};
         // Partial remainder stays below the divisor, so both arms fit the width.
         if (trial >= {1'b0, divisor}) begin
            part_in = diff[hrs_pkg::CircW-1:0];
         end else begin
            part_in = trial[hrs_pkg::CircW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      part_ff  <= part_in;
   end

   assign busy = (cnt_ff != '0);
   assign rem  = part_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hvac_relay_supervisor.sv -----
// HVAC relay supervisor top level: request intake, microcoded sequencer, the
// relay and timer datapath, configuration registers and the response register.
// Depends on hrs_pkg and hrs_rem_unit.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_tvalid/tready    | req_tuser = kind, req_tdata = item fields
//   rsp     | out       | rsp_tvalid/tready    | rsp_tdata = relays, verdict, stored state
//   csr     | in        | csr_we (no wait)     | csr_index, csr_wdata
//
// Heartbeat, command and lockout requests run dispatch, their own step and respond.
// A tick runs failsafe, drive and mark; if that starts the minute timer it goes on to
// interlock, else it waits for the circulation remainder, then the minute loop handles
// each whole elapsed minute one by one before interlock; respond comes last.
// Synchronous reset restores all state and registers but the captured request fields
// and response data. A new request is taken once the previous response sits in the
// output register; a stalled response holds the sequencer at its final step.
`default_nettype none

module hvac_relay_supervisor #(
   parameter int SEQ_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata, lowest bit up: now_ms[31:0], heat_demand, cool_demand, cmd_seq[15:0],
   // cmd_sync_request, cmd_hvac_mode[2:0], cmd_fan_mode[1:0], cmd_setpoint[15:0],
   // cmd_filter_reset, lockout_value, zero fill to 80 bits
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [hrs_pkg::ReqW-1:0]    req_tdata,
   // req_tuser: kind[1:0]
   input  wire logic [1:0]                  req_tuser,
   // rsp_tdata, lowest bit up: heat_relay, cool_relay, fan_relay, failsafe_on,
   // accepted, stale, sync_flag, filter_reset_done, filter_runtime[31:0],
   // target_setpoint[15:0], hvac_mode_now[2:0], fan_mode_now[1:0], zero fill
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [hrs_pkg::RspW-1:0]         rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [hrs_pkg::TimeW-1:0]   csr_wdata
);

   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   localparam int TW = hrs_pkg::TimeW;
   localparam int CW = hrs_pkg::CircW;
   localparam int PW = hrs_pkg::PcW;

   seq_state_type state_ff, state_in;
   logic [PW-1:0] pc_ff, pc_in;

   // Captured request fields.
   hrs_pkg::kind_type         kind_ff, kind_in;
   logic [TW-1:0]             now_ff, now_in;
   logic                      heat_dem_ff, heat_dem_in;
   logic                      cool_dem_ff, cool_dem_in;
   logic [hrs_pkg::CmdSeqW-1:0] seq_ff, seq_in;
   logic                      sync_req_ff, sync_req_in;
   logic [hrs_pkg::HvacW-1:0] hvac_req_ff, hvac_req_in;
   logic [hrs_pkg::FanW-1:0]  fan_req_ff, fan_req_in;
   logic [hrs_pkg::SetpW-1:0] setp_req_ff, setp_req_in;
   logic                      frst_req_ff, frst_req_in;
   logic                      lock_req_ff, lock_req_in;

   // Supervisor state.
   logic [SEQ_BITS-1:0]       last_seq_ff, last_seq_in;
   logic [TW-1:0]             hb_time_ff, hb_time_in;
   logic                      lockout_ff, lockout_in;
   logic                      failsafe_ff, failsafe_in;
   logic                      heat_ff, heat_in;
   logic                      cool_ff, cool_in;
   logic                      fan_ff, fan_in;
   logic [hrs_pkg::FanW-1:0]  fan_mode_ff, fan_mode_in;
   logic [hrs_pkg::HvacW-1:0] hvac_mode_ff, hvac_mode_in;
   logic [hrs_pkg::SetpW-1:0] setpoint_ff, setpoint_in;
   logic [TW-1:0]             runtime_ff, runtime_in;
   logic [TW-1:0]             mark_ff, mark_in;
   logic [TW-1:0]             circ_min_ff, circ_min_in;
   logic [CW-1:0]             circ_rem_ff, circ_rem_in;

   // Per-request verdict flags.
   logic acc_ff, acc_in;
   logic stale_ff, stale_in;
   logic sync_done_ff, sync_done_in;
   logic frd_ff, frd_in;

   // Configuration registers.
   logic [TW-1:0] fs_timeout_ff, fs_timeout_in;
   logic [CW-1:0] circ_period_ff, circ_period_in;
   logic [CW-1:0] circ_dur_ff, circ_dur_in;
   logic          spare_ff, spare_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [hrs_pkg::RspW-1:0] rsp_data_ff, rsp_data_in;

   hrs_pkg::uword_type uw;
   logic               run;
   logic               out_free;
   logic               rem_start;
   logic               rem_busy;
   logic [CW-1:0]      rem_value;
   logic               minute_due;
   logic [TW-1:0]      since_mark;
   logic [TW-1:0]      since_hb;
   logic [31:0]        seq_wide;
   logic [SEQ_BITS-1:0] seq_v;
   logic [SEQ_BITS-1:0] seq_diff;
   logic               seq_newer;
   logic [CW:0]        rem_inc;
   logic [CW-1:0]      rem_next;

   assign run        = (state_ff == SEQ_RUN);
   assign uw         = hrs_pkg::ucode(pc_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rem_start  = run && (uw.op == hrs_pkg::OP_MOD_START);
   assign since_mark = now_ff - mark_ff;
   assign minute_due = (since_mark >= hrs_pkg::MinuteMs);
   assign since_hb   = now_ff - hb_time_ff;

   // Sequence numbers compare modulo 2^SEQ_BITS; newer means a nonzero
   // difference below half the range.
   assign seq_wide  = {16'b0, seq_ff};
   assign seq_v     = seq_wide[SEQ_BITS-1:0];
   assign seq_diff  = seq_v - last_seq_ff;
   assign seq_newer = (seq_diff != '0) && !seq_diff[SEQ_BITS-1];

   // The remainder of the circulation counter tracks it minute by minute; when
   // the counter wraps to zero the remainder restarts at zero too.
   assign rem_inc  = {1'b0, circ_rem_ff} + (CW+1)'(1);
   always_comb begin
      if (circ_min_ff == '1) begin
         rem_next = '0;
      end else if (rem_inc == {1'b0, circ_period_ff}) begin
         rem_next = '0;
      end else begin
         rem_next = rem_inc[CW-1:0];
      end
   end

   hrs_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (circ_min_ff),
      .divisor  (circ_period_ff),
      .busy     (rem_busy),
      .rem      (rem_value)
   );

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      heat_dem_in   = heat_dem_ff;
      cool_dem_in   = cool_dem_ff;
      seq_in        = seq_ff;
      sync_req_in   = sync_req_ff;
      hvac_req_in   = hvac_req_ff;
      fan_req_in    = fan_req_ff;
      setp_req_in   = setp_req_ff;
      frst_req_in   = frst_req_ff;
      lock_req_in   = lock_req_ff;
      last_seq_in   = last_seq_ff;
      hb_time_in    = hb_time_ff;
      lockout_in    = lockout_ff;
      failsafe_in   = failsafe_ff;
      heat_in       = heat_ff;
      cool_in       = cool_ff;
      fan_in        = fan_ff;
      fan_mode_in   = fan_mode_ff;
      hvac_mode_in  = hvac_mode_ff;
      setpoint_in   = setpoint_ff;
      runtime_in    = runtime_ff;
      mark_in       = mark_ff;
      circ_min_in   = circ_min_ff;
      circ_rem_in   = circ_rem_ff;
      acc_in        = acc_ff;
      stale_in      = stale_ff;
      sync_done_in  = sync_done_ff;
      frd_in        = frd_ff;
      fs_timeout_in  = fs_timeout_ff;
      circ_period_in = circ_period_ff;
      circ_dur_in    = circ_dur_ff;
      spare_in       = spare_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         case (hrs_pkg::csr_index_type'(csr_index))
            hrs_pkg::CSR_FS_TIMEOUT:   fs_timeout_in  = csr_wdata;
            hrs_pkg::CSR_CIRC_PERIOD:  circ_period_in = csr_wdata[CW-1:0];
            hrs_pkg::CSR_CIRC_DUR:     circ_dur_in    = csr_wdata[CW-1:0];
            hrs_pkg::CSR_SPARE_ACTIVE: spare_in       = csr_wdata[0];
            default: ;
         endcase
      end

      if (!run) begin
         if (req_tvalid) begin
            state_in     = SEQ_RUN;
            pc_in        = hrs_pkg::PC_DISPATCH;
            kind_in      = hrs_pkg::kind_type'(req_tuser);
            now_in       = req_tdata[31:0];
            heat_dem_in  = req_tdata[32];
            cool_dem_in  = req_tdata[33];
            seq_in       = req_tdata[49:34];
            sync_req_in  = req_tdata[50];
            hvac_req_in  = req_tdata[53:51];
            fan_req_in   = req_tdata[55:54];
            setp_req_in  = req_tdata[71:56];
            frst_req_in  = req_tdata[72];
            lock_req_in  = req_tdata[73];
            acc_in       = 1'b0;
            stale_in     = 1'b0;
            sync_done_in = 1'b0;
            frd_in       = 1'b0;
         end
      end else begin
         case (uw.op)
            hrs_pkg::OP_FAILSAFE: begin
               failsafe_in = (since_hb >= fs_timeout_ff);
            end
            hrs_pkg::OP_DRIVE: begin
               if (failsafe_ff || lockout_ff) begin
                  heat_in = 1'b0;
                  cool_in = 1'b0;
                  fan_in  = 1'b0;
               end else if (heat_dem_ff) begin
                  heat_in = 1'b1;
                  cool_in = 1'b0;
                  fan_in  = 1'b0;
               end else if (cool_dem_ff) begin
                  heat_in = 1'b0;
                  cool_in = 1'b1;
                  fan_in  = 1'b0;
               end else begin
                  heat_in = 1'b0;
                  cool_in = 1'b0;
                  // In circulate mode the fan keeps whatever the window left.
                  if (fan_mode_ff == hrs_pkg::FAN_ALWAYS_ON && !spare_ff) begin
                     fan_in = 1'b1;
                  end else if (fan_mode_ff != hrs_pkg::FAN_CIRCULATE) begin
                     fan_in = 1'b0;
                  end
               end
            end
            hrs_pkg::OP_MARK: begin
               if (mark_ff == '0) begin
                  mark_in = now_ff;
               end
            end
            hrs_pkg::OP_LOAD_REM: begin
               circ_rem_in = rem_value;
            end
            hrs_pkg::OP_MINUTE: begin
               mark_in = mark_ff + hrs_pkg::MinuteMs;
               if (heat_ff || cool_ff || fan_ff || spare_ff) begin
                  runtime_in = runtime_ff + hrs_pkg::MinuteSec;
               end
               if (!failsafe_ff && !lockout_ff && fan_mode_ff == hrs_pkg::FAN_CIRCULATE) begin
                  if (circ_period_ff != '0 && circ_dur_ff != '0) begin
                     circ_min_in = circ_min_ff + TW'(1);
                     circ_rem_in = rem_next;
                     fan_in      = (rem_next < circ_dur_ff) && !heat_ff && !cool_ff
                                   && !spare_ff;
                  end
               end else begin
                  circ_min_in = '0;
                  circ_rem_in = '0;
               end
            end
            hrs_pkg::OP_INTERLOCK: begin
               if (failsafe_ff || lockout_ff) begin
                  heat_in = 1'b0;
                  cool_in = 1'b0;
                  fan_in  = 1'b0;
               end else if (heat_ff) begin
                  cool_in = 1'b0;
                  fan_in  = 1'b0;
               end else if (cool_ff) begin
                  fan_in  = 1'b0;
               end
            end
            hrs_pkg::OP_HEARTBEAT: begin
               hb_time_in = now_ff;
            end
            hrs_pkg::OP_COMMAND: begin
               if (last_seq_ff != '0 && !seq_newer) begin
                  stale_in = 1'b1;
               end else begin
                  last_seq_in = seq_v;
                  acc_in      = 1'b1;
                  if (sync_req_ff) begin
                     sync_done_in = 1'b1;
                  end else begin
                     hvac_mode_in = hvac_req_ff;
                     fan_mode_in  = fan_req_ff;
                     setpoint_in  = setp_req_ff;
                     if (frst_req_ff) begin
                        runtime_in = '0;
                        frd_in     = 1'b1;
                     end
                  end
               end
            end
            hrs_pkg::OP_LOCKOUT: begin
               lockout_in = lock_req_ff;
               if (lock_req_ff) begin
                  heat_in = 1'b0;
                  cool_in = 1'b0;
                  fan_in  = 1'b0;
               end
            end
            hrs_pkg::OP_RESPOND: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {3'b0, fan_mode_ff, hvac_mode_ff, setpoint_ff, runtime_ff,
                                  frd_ff, sync_done_ff, stale_ff, acc_ff, failsafe_ff,
                                  fan_ff, cool_ff, heat_ff};
               end
            end
            default: ;
         endcase

         case (uw.cond)
            hrs_pkg::COND_NEXT:      pc_in = pc_ff + PW'(1);
            hrs_pkg::COND_ALWAYS:    pc_in = uw.target;
            hrs_pkg::COND_KIND:      pc_in = hrs_pkg::entry_addr(kind_ff);
            hrs_pkg::COND_MARK_ZERO: pc_in = (mark_ff == '0) ? uw.target : pc_ff + PW'(1);
            hrs_pkg::COND_REM_BUSY:  pc_in = rem_busy ? uw.target : pc_ff + PW'(1);
            hrs_pkg::COND_NO_MINUTE: pc_in = minute_due ? pc_ff + PW'(1) : uw.target;
            hrs_pkg::COND_END: begin
               if (out_free) begin
                  state_in = SEQ_IDLE;
               end
            end
            default: pc_in = hrs_pkg::PC_RESPOND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         pc_ff          <= hrs_pkg::PC_DISPATCH;
         last_seq_ff    <= '0;
         hb_time_ff     <= '0;
         lockout_ff     <= 1'b0;
         failsafe_ff    <= 1'b0;
         heat_ff        <= 1'b0;
         cool_ff        <= 1'b0;
         fan_ff         <= 1'b0;
         fan_mode_ff    <= '0;
         hvac_mode_ff   <= '0;
         setpoint_ff    <= '0;
         runtime_ff     <= '0;
         mark_ff        <= '0;
         circ_min_ff    <= '0;
         circ_rem_ff    <= '0;
         acc_ff         <= 1'b0;
         stale_ff       <= 1'b0;
         sync_done_ff   <= 1'b0;
         frd_ff         <= 1'b0;
         fs_timeout_ff  <= hrs_pkg::FsTimeoutReset;
         circ_period_ff <= '0;
         circ_dur_ff    <= '0;
         spare_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pc_ff          <= pc_in;
         last_seq_ff    <= last_seq_in;
         hb_time_ff     <= hb_time_in;
         lockout_ff     <= lockout_in;
         failsafe_ff    <= failsafe_in;
         heat_ff        <= heat_in;
         cool_ff        <= cool_in;
         fan_ff         <= fan_in;
         fan_mode_ff    <= fan_mode_in;
         hvac_mode_ff   <= hvac_mode_in;
         setpoint_ff    <= setpoint_in;
         runtime_ff     <= runtime_in;
         mark_ff        <= mark_in;
         circ_min_ff    <= circ_min_in;
         circ_rem_ff    <= circ_rem_in;
         acc_ff         <= acc_in;
         stale_ff       <= stale_in;
         sync_done_ff   <= sync_done_in;
         frd_ff         <= frd_in;
         fs_timeout_ff  <= fs_timeout_in;
         circ_period_ff <= circ_period_in;
         circ_dur_ff    <= circ_dur_in;
         spare_ff       <= spare_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      now_ff       <= now_in;
      heat_dem_ff  <= heat_dem_in;
      cool_dem_ff  <= cool_dem_in;
      seq_ff       <= seq_in;
      sync_req_ff  <= sync_req_in;
      hvac_req_ff  <= hvac_req_in;
      fan_req_ff   <= fan_req_in;
      setp_req_ff  <= setp_req_in;
      frst_req_ff  <= frst_req_in;
      lock_req_ff  <= lock_req_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = !run;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sim/hvac_relay_supervisor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hvac_relay_supervisor: directed and random requests,
// checked against a cycle-free predictor of relays, failsafe, command order and timers.
// Depends on hrs_pkg and the hvac_relay_supervisor RTL.

module hvac_relay_supervisor_tb;

   localparam int StallLimit = 200000;
   localparam logic [hrs_pkg::FanW-1:0] FAN_AUTO     = 2'd0;
   localparam logic [hrs_pkg::FanW-1:0] FAN_RESERVED = 2'd3;

   // Layout of req_tdata, highest field first.
   typedef struct packed {
      logic [5:0]  fill;
      logic        lockout_value;
      logic        cmd_filter_reset;
      logic [15:0] cmd_setpoint;
      logic [1:0]  cmd_fan_mode;
      logic [2:0]  cmd_hvac_mode;
      logic        cmd_sync_request;
      logic [15:0] cmd_seq;
      logic        cool_demand;
      logic        heat_demand;
      logic [31:0] now_ms;
   } req_item_type;

   // Layout of rsp_tdata, highest field first.
   typedef struct packed {
      logic [2:0]  fill;
      logic [1:0]  fan_mode_now;
      logic [2:0]  hvac_mode_now;
      logic [15:0] target_setpoint;
      logic [31:0] filter_runtime;
      logic        filter_reset_done;
      logic        sync_flag;
      logic        stale;
      logic        accepted;
      logic        failsafe_on;
      logic        fan_relay;
      logic        cool_relay;
      logic        heat_relay;
   } rsp_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [hrs_pkg::ReqW-1:0]  req_tdata;
   logic [1:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [hrs_pkg::RspW-1:0]  rsp_tdata;
   logic                      csr_we;
   logic [1:0]                csr_index;
   logic [hrs_pkg::TimeW-1:0] csr_wdata;

   hvac_relay_supervisor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predicted supervisor state and register copies.
   logic [31:0] cfg_timeout;
   logic [10:0] cfg_period;
   logic [10:0] cfg_duration;
   logic        cfg_spare;
   logic [15:0] seq_last;
   logic [31:0] hb_ms;
   logic        lock_on;
   logic        fs_on;
   logic        heat_on;
   logic        cool_on;
   logic        fan_on;
   logic [1:0]  fan_mode_st;
   logic [2:0]  hvac_st;
   logic [15:0] setp_st;
   logic [31:0] runtime_s;
   logic [31:0] mark_ms;
   logic [31:0] circ_count;

   rsp_item_type expected_reports[$];
   int           mismatch_count;
   int           idle_cycles;
   bit           steady;
   logic [31:0]  stim_ms;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rsp_item_type supervise_item(input hrs_pkg::kind_type kind,
                                                   input req_item_type f);
      rsp_item_type r;
      logic [15:0]  seq_gap;
      logic [31:0]  circ_rem;
      r = '0;
      case (kind)
         hrs_pkg::KIND_TICK: begin
            fs_on = (f.now_ms - hb_ms) >= cfg_timeout;
            if (fs_on || lock_on) begin
               {heat_on, cool_on, fan_on} = 3'b000;
            end else if (f.heat_demand) begin
               {heat_on, cool_on, fan_on} = 3'b100;
            end else if (f.cool_demand) begin
               {heat_on, cool_on, fan_on} = 3'b010;
            end else begin
               heat_on = 1'b0;
               cool_on = 1'b0;
               // In circulate mode the fan keeps whatever the minute window set.
               if (fan_mode_st == hrs_pkg::FAN_ALWAYS_ON && !cfg_spare) fan_on = 1'b1;
               else if (fan_mode_st != hrs_pkg::FAN_CIRCULATE) fan_on = 1'b0;
            end
            if (mark_ms == 0) begin
               mark_ms = f.now_ms;
            end else begin
               while ((f.now_ms - mark_ms) >= hrs_pkg::MinuteMs) begin
                  mark_ms = mark_ms + hrs_pkg::MinuteMs;
                  if (heat_on || cool_on || fan_on || cfg_spare) begin
                     runtime_s = runtime_s + hrs_pkg::MinuteSec;
                  end
                  if (!fs_on && !lock_on && fan_mode_st == hrs_pkg::FAN_CIRCULATE) begin
                     if (cfg_period != 0 && cfg_duration != 0) begin
                        circ_count = circ_count + 1;
                        circ_rem = circ_count % {21'd0, cfg_period};
                        fan_on = (circ_rem < {21'd0, cfg_duration}) && !heat_on && !cool_on
                                 && !cfg_spare;
                     end
                  end else begin
                     circ_count = '0;
                  end
               end
            end
            if (fs_on || lock_on) {heat_on, cool_on, fan_on} = 3'b000;
            if (heat_on) begin
               cool_on = 1'b0;
               fan_on = 1'b0;
            end else if (cool_on) begin
               fan_on = 1'b0;
            end
         end
         hrs_pkg::KIND_HEARTBEAT: begin
            hb_ms = f.now_ms;
         end
         hrs_pkg::KIND_COMMAND: begin
            seq_gap = f.cmd_seq - seq_last;
            if (seq_last != 0 && !(seq_gap != 0 && seq_gap < 16'h8000)) begin
               r.stale = 1'b1;
            end else begin
               seq_last = f.cmd_seq;
               r.accepted = 1'b1;
               if (f.cmd_sync_request) begin
                  r.sync_flag = 1'b1;
               end else begin
                  hvac_st = f.cmd_hvac_mode;
                  fan_mode_st = f.cmd_fan_mode;
                  setp_st = f.cmd_setpoint;
                  if (f.cmd_filter_reset) begin
                     runtime_s = '0;
                     r.filter_reset_done = 1'b1;
                  end
               end
            end
         end
         hrs_pkg::KIND_LOCKOUT: begin
            lock_on = f.lockout_value;
            if (lock_on) {heat_on, cool_on, fan_on} = 3'b000;
         end
         default: begin
         end
      endcase
      r.heat_relay = heat_on;
      r.cool_relay = cool_on;
      r.fan_relay = fan_on;
      r.failsafe_on = fs_on;
      r.filter_runtime = runtime_s;
      r.target_setpoint = setp_st;
      r.hvac_mode_now = hvac_st;
      r.fan_mode_now = fan_mode_st;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (expected_reports.size() == 0) begin
            $display("%0t: response with no request waiting, expected none actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("heat_relay", want.heat_relay, seen.heat_relay);
            check_field("cool_relay", want.cool_relay, seen.cool_relay);
            check_field("fan_relay", want.fan_relay, seen.fan_relay);
            check_field("failsafe_on", want.failsafe_on, seen.failsafe_on);
            check_field("accepted", want.accepted, seen.accepted);
            check_field("stale", want.stale, seen.stale);
            check_field("sync_flag", want.sync_flag, seen.sync_flag);
            check_field("filter_reset_done", want.filter_reset_done, seen.filter_reset_done);
            check_field("filter_runtime", want.filter_runtime, seen.filter_runtime);
            check_field("target_setpoint", want.target_setpoint, seen.target_setpoint);
            check_field("hvac_mode_now", want.hvac_mode_now, seen.hvac_mode_now);
            check_field("fan_mode_now", want.fan_mode_now, seen.fan_mode_now);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(0, 99) >= 13);
   end

   // Counts cycles in which neither channel moves a request or a response.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == StallLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(input hrs_pkg::kind_type kind, input req_item_type f);
      if (!steady && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= f;
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(supervise_item(kind, f));
   endtask

   // Fields that a kind ignores still carry random bits.
   function automatic req_item_type noise_fields();
      logic [95:0] raw;
      req_item_type f;
      raw = {$urandom, $urandom, $urandom};
      f = raw[79:0];
      f.fill = '0;
      return f;
   endfunction

   task automatic send_tick(input logic [31:0] now, input logic heat, input logic cool);
      req_item_type f;
      f = noise_fields();
      f.now_ms = now;
      f.heat_demand = heat;
      f.cool_demand = cool;
      send_item(hrs_pkg::KIND_TICK, f);
   endtask

   task automatic send_heartbeat(input logic [31:0] now);
      req_item_type f;
      f = noise_fields();
      f.now_ms = now;
      send_item(hrs_pkg::KIND_HEARTBEAT, f);
   endtask

   task automatic send_command(input logic [15:0] seq, input logic sync, input logic [2:0] hvac,
                               input logic [1:0] fan, input logic [15:0] setp,
                               input logic clear_filter);
      req_item_type f;
      f = noise_fields();
      f.cmd_seq = seq;
      f.cmd_sync_request = sync;
      f.cmd_hvac_mode = hvac;
      f.cmd_fan_mode = fan;
      f.cmd_setpoint = setp;
      f.cmd_filter_reset = clear_filter;
      send_item(hrs_pkg::KIND_COMMAND, f);
   endtask

   task automatic send_lockout(input logic value);
      req_item_type f;
      f = noise_fields();
      f.lockout_value = value;
      send_item(hrs_pkg::KIND_LOCKOUT, f);
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] timeout, input logic [10:0] period,
                            input logic [10:0] duration, input logic spare);
      csr_we <= 1'b1;
      csr_index <= hrs_pkg::CSR_FS_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= hrs_pkg::CSR_CIRC_PERIOD;
      csr_wdata <= {21'd0, period};
      @(posedge clock);
      csr_index <= hrs_pkg::CSR_CIRC_DUR;
      csr_wdata <= {21'd0, duration};
      @(posedge clock);
      csr_index <= hrs_pkg::CSR_SPARE_ACTIVE;
      csr_wdata <= {31'd0, spare};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_timeout = timeout;
      cfg_period = period;
      cfg_duration = duration;
      cfg_spare = spare;
      @(posedge clock);
   endtask

   // Sequence zero, the half-range boundary, duplicates and sync-only commands.
   task automatic test_command_order();
      send_command(16'h0000, 1'b0, 3'd7, hrs_pkg::FAN_ALWAYS_ON, 16'hFFFF, 1'b1);
      send_command(16'h0000, 1'b1, 3'd2, hrs_pkg::FAN_CIRCULATE, 16'h1234, 1'b1);
      send_command(16'h7FFF, 1'b0, 3'd0, FAN_AUTO, 16'h0000, 1'b0);
      send_command(16'hFFFF, 1'b0, 3'd1, hrs_pkg::FAN_ALWAYS_ON, 16'h0101, 1'b1);
      send_command(16'h7FFF, 1'b0, 3'd3, hrs_pkg::FAN_ALWAYS_ON, 16'h0202, 1'b0);
      send_command(16'hFFFE, 1'b0, 3'd5, FAN_RESERVED, 16'd220, 1'b0);
   endtask

   task automatic test_relay_calls();
      send_tick(32'd0, 1'b1, 1'b1);
      send_tick(32'd0, 1'b0, 1'b1);
      send_tick(32'd0, 1'b0, 1'b0);
      send_command(16'h0003, 1'b0, 3'd4, hrs_pkg::FAN_ALWAYS_ON, 16'd215, 1'b0);
      send_tick(32'd0, 1'b0, 1'b0);
      send_lockout(1'b1);
      send_tick(32'd0, 1'b1, 1'b0);
      send_lockout(1'b0);
      send_tick(32'd0, 1'b0, 1'b0);
   endtask

   // The mark starts one minute before the wrap, so it lands on zero and restarts.
   task automatic test_minute_wrap();
      send_heartbeat(32'hFFFF_15A0);
      send_tick(32'hFFFF_15A0, 1'b1, 1'b0);
      send_tick(32'd0, 1'b1, 1'b0);
      send_tick(32'h0000_2000, 1'b0, 1'b0);
      stim_ms = 32'h0000_2000 + 32'd1440 * hrs_pkg::MinuteMs + 32'd123;
      send_heartbeat(stim_ms);
      send_tick(stim_ms, 1'b0, 1'b1);
   endtask

   // A heartbeat alone leaves the failsafe set until the next tick.
   task automatic test_failsafe();
      stim_ms = stim_ms + 32'd400000;
      send_tick(stim_ms, 1'b1, 1'b0);
      send_heartbeat(stim_ms);
      send_tick(stim_ms, 1'b1, 1'b0);
   endtask

   task automatic test_random_phase(input logic [31:0] timeout, input logic [10:0] period,
                                    input logic [10:0] duration, input logic spare,
                                    input int count, input bit no_gaps);
      int          pick;
      int          roll;
      logic [15:0] seq;
      wait_for_reports();
      configure(timeout, period, duration, spare);
      steady = no_gaps;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // Time only moves forward; a rare long jump runs up to a day of minutes.
            if ($urandom_range(0, 99) < 2) stim_ms = stim_ms + $urandom_range(600000, 86400000);
            else stim_ms = stim_ms + $urandom_range(0, 150000);
            send_tick(stim_ms, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         end else if (pick < 60) begin
            send_heartbeat(($urandom_range(0, 99) < 85) ? stim_ms : $urandom);
         end else if (pick < 85) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) seq = seq_last + 16'($urandom_range(1, 300));
            else if (roll < 85) seq = seq_last - 16'($urandom_range(0, 32768));
            else if (roll < 92) seq = 16'h0000;
            else seq = 16'($urandom);
            send_command(seq, $urandom_range(0, 4) == 0, 3'($urandom),
                         ($urandom_range(0, 1) == 1) ? hrs_pkg::FAN_CIRCULATE : 2'($urandom),
                         16'($urandom), $urandom_range(0, 2) == 0);
         end else begin
            send_lockout($urandom_range(0, 9) < 3);
         end
         if ($urandom_range(0, 99) < 2) wait_for_reports();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= hrs_pkg::KIND_TICK;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= hrs_pkg::CSR_FS_TIMEOUT;
      csr_wdata <= '0;
      cfg_timeout = hrs_pkg::FsTimeoutReset;
      cfg_period = '0;
      cfg_duration = '0;
      cfg_spare = 1'b0;
      seq_last = '0;
      hb_ms = '0;
      lock_on = 1'b0;
      fs_on = 1'b0;
      {heat_on, cool_on, fan_on} = 3'b000;
      fan_mode_st = FAN_AUTO;
      hvac_st = '0;
      setp_st = '0;
      runtime_s = '0;
      mark_ms = '0;
      circ_count = '0;
      mismatch_count = 0;
      steady = 1'b0;
      stim_ms = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_command_order();
      test_relay_calls();
      test_minute_wrap();
      test_failsafe();
      test_random_phase(32'd300000, 11'd3, 11'd1, 1'b0, 80, 1'b0);
      test_random_phase(32'd0, 11'd0, 11'd1440, 1'b0, 70, 1'b0);
      test_random_phase(32'hFFFF_FFFF, 11'd1440, 11'd1440, 1'b1, 80, 1'b1);
      test_random_phase(32'd120000, 11'd1023, 11'd7, 1'b0, 80, 1'b0);
      test_random_phase($urandom_range(60000, 900000), 11'($urandom_range(1, 12)),
                        11'($urandom_range(0, 12)), 1'($urandom), 90, 1'b0);

      wait_for_reports();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
